// ----- hdl/uigfd_pkg.sv -----
package uigfd_pkg;

    // field and register widths
    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 13;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 22;
    localparam int BAUD_W  = 22;
    localparam int DBITS_W = 4;
    localparam int GAP_W   = 16;

    // character bits (at most 1 + 15 + 2 + 1) and the dividend bits * 4000
    localparam int BITS_W  = 5;
    localparam int NUM_W   = 17;

    localparam int BUFFER_BYTES_DEF = 4096;

    localparam int BAUD_RESET      = 115200;
    localparam int DATA_BITS_RESET = 8;
    localparam int BAUD_DEFAULT    = 9600;
    localparam int MS_SCALE        = 4000;
    localparam int GAP_MIN         = 3;
    localparam int GAP_MAX         = 50;
    localparam int GAP_RESET       = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_BYTE  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_FLUSH = 2'd2
    } t_cmd;

    typedef enum logic [IDX_W-1:0] {
        REG_BAUD         = 3'd0,
        REG_DATA_BITS    = 3'd1,
        REG_TWO_STOP     = 3'd2,
        REG_PARITY       = 3'd3,
        REG_EXPLICIT_GAP = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] index;
        logic [CFG_W-1:0] data;
    } t_cfg_write;

    typedef struct packed {
        logic             busy;
        logic [GAP_W-1:0] gap_ms;
    } t_gap_status;

endpackage

// ----- hdl/uigfd_gap.sv -----
module uigfd_gap
    import uigfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg_write  i_cfg,
    output t_gap_status o_status
);

    typedef enum logic [2:0] {
        G_IDLE = 3'b001,
        G_LOAD = 3'b010,
        G_DIV  = 3'b100
    } t_gap_state;

    t_gap_state r_state;

    logic [BAUD_W-1:0]  r_baud;
    logic [DBITS_W-1:0] r_data_bits;
    logic               r_two_stop;
    logic               r_parity;
    logic [GAP_W-1:0]   r_explicit;
    logic [GAP_W-1:0]   r_gap;

    logic [BAUD_W-1:0]  r_div;
    logic [BAUD_W-1:0]  r_rem;
    logic [NUM_W-1:0]   r_quo;
    logic [BITS_W-1:0]  r_step;

    logic [BITS_W-1:0]  char_bits;
    logic [NUM_W-1:0]   dividend;
    logic [BAUD_W:0]    trial;
    logic               fits;
    logic [BAUD_W-1:0]  n_rem;
    logic [NUM_W-1:0]   n_quo;
    logic [GAP_W-1:0]   clamped;
    logic               known_idx;

    always_comb begin
        char_bits = BITS_W'(1) + BITS_W'(r_data_bits) + (r_two_stop ? BITS_W'(2) : BITS_W'(1))
                  + BITS_W'(r_parity);
        dividend  = NUM_W'(char_bits * MS_SCALE);
    end

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_quo[NUM_W-1]};
        fits  = (trial >= {1'b0, r_div});
        n_rem = fits ? BAUD_W'(trial - {1'b0, r_div}) : trial[BAUD_W-1:0];
        n_quo = {r_quo[NUM_W-2:0], fits};
    end

    // gap = quotient + 1, held to GAP_MIN..GAP_MAX
    always_comb begin
        if (n_quo >= NUM_W'(GAP_MAX - 1)) begin
            clamped = GAP_W'(GAP_MAX);
        end else if (n_quo < NUM_W'(GAP_MIN - 1)) begin
            clamped = GAP_W'(GAP_MIN);
        end else begin
            clamped = GAP_W'(n_quo) + GAP_W'(1);
        end
    end

    always_comb begin
        case (i_cfg.index)
            REG_BAUD, REG_DATA_BITS, REG_TWO_STOP, REG_PARITY, REG_EXPLICIT_GAP: known_idx = 1'b1;
            default: known_idx = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baud      <= BAUD_W'(BAUD_RESET);
            r_data_bits <= DBITS_W'(DATA_BITS_RESET);
            r_two_stop  <= 1'b0;
            r_parity    <= 1'b0;
            r_explicit  <= '0;
        end else if (i_cfg.valid && r_state == G_IDLE) begin
            case (i_cfg.index)
                REG_BAUD:         r_baud      <= i_cfg.data[BAUD_W-1:0];
                REG_DATA_BITS:    r_data_bits <= i_cfg.data[DBITS_W-1:0];
                REG_TWO_STOP:     r_two_stop  <= i_cfg.data[0];
                REG_PARITY:       r_parity    <= i_cfg.data[0];
                REG_EXPLICIT_GAP: r_explicit  <= i_cfg.data[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
            r_gap   <= GAP_W'(GAP_RESET);
            r_step  <= '0;
        end else begin
            case (r_state)
                G_IDLE: begin
                    if (i_cfg.valid && known_idx) begin
                        r_state <= G_LOAD;
                    end
                end
                G_LOAD: begin
                    if (r_explicit != '0) begin
                        r_gap   <= r_explicit;
                        r_state <= G_IDLE;
                    end else begin
                        r_step  <= '0;
                        r_state <= G_DIV;
                    end
                end
                G_DIV: begin
                    r_step <= r_step + BITS_W'(1);
                    if (r_step == BITS_W'(NUM_W - 1)) begin
                        r_gap   <= clamped;
                        r_state <= G_IDLE;
                    end
                end
                default: r_state <= G_IDLE;
            endcase
        end
    end

    // datapath of the divider
    always_ff @(posedge i_clk) begin
        if (r_state == G_LOAD) begin
            r_div <= (r_baud == '0) ? BAUD_W'(BAUD_DEFAULT) : r_baud;
            r_rem <= '0;
            r_quo <= dividend;
        end else if (r_state == G_DIV) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_status.busy   = (r_state != G_IDLE);
    assign o_status.gap_ms = r_gap;

endmodule

// ----- hdl/uart_idle_gap_frame_delimiter.sv -----
// Cuts a received serial byte stream into frames by line silence, Modbus RTU
// style. Each input word is a received byte, a one-millisecond tick or a flush.
// A byte is passed straight through with the running frame length; it carries
// frame_end when the frame fills BUFFER_BYTES. A tick that brings the idle time
// up to the gap limit, or a flush, closes a pending frame with a word that has
// no byte and the final length. Ticks and flushes with nothing pending, and
// command three, give no output word. The gap limit is explicit_gap_ms when that
// is nonzero, else bits*4000/baud + 1 ms held to 3..50 ms (baud 0 counts as
// 9600). Rate: one input word per clock while input ready is high, with the
// output register decoupling the two sides; input waits while that register
// holds a word the receiver has not taken, and during configuration as below.
// After each write to a known register the gap limit is worked out again: the
// load state, then, when explicit_gap_ms is zero, the divide state of a
// bit-serial divider, one step per quotient bit. Configuration ready is low in
// these states; input ready is low in them, for the write cycle itself and
// whenever configuration valid is high. Write configuration only while the block is idle.
module uart_idle_gap_frame_delimiter
    import uigfd_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [BYTE_W-1:0] i_rx_byte,

    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_has_byte,
    output logic              o_frame_end,
    output logic [LEN_W-1:0]  o_frame_length,

    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    // frame counter holds 0..BUFFER_BYTES-1 between words, the new count up to BUFFER_BYTES
    localparam int CW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES + 1) : 1;

    t_cfg_write  cfg_wr;
    t_gap_status gap;

    logic [CW-1:0]     r_count;
    logic [GAP_W-1:0]  r_idle;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_has_byte;
    logic              r_frame_end;
    logic [LEN_W-1:0]  r_frame_length;

    logic              in_acc;
    logic              out_free;
    logic [CW-1:0]     cnt_inc;
    logic [GAP_W-1:0]  idle_inc;

    logic [CW-1:0]     n_count;
    logic [GAP_W-1:0]  n_idle;
    logic              n_emit;
    logic              n_has_byte;
    logic              n_frame_end;
    logic [CW-1:0]     n_len;

    assign cfg_wr.valid = i_cfg_valid && o_cfg_ready;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    uigfd_gap u_gap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_wr),
        .o_status (gap)
    );

    // hold input off while the output word is not taken, while the gap is recomputed and in the write cycle itself
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = out_free && !gap.busy && !i_cfg_valid;
    assign o_cfg_ready = !gap.busy;
    assign in_acc      = i_in_valid && o_in_ready;

    assign cnt_inc  = r_count + CW'(1);
    assign idle_inc = (r_idle == '1) ? r_idle : r_idle + GAP_W'(1);

    always_comb begin
        n_count     = r_count;
        n_idle      = r_idle;
        n_emit      = 1'b0;
        n_has_byte  = 1'b0;
        n_frame_end = 1'b0;
        n_len       = r_count;
        case (t_cmd'(i_command))
            CMD_BYTE: begin
                // pass the byte through; close the frame once the buffer is full
                n_idle     = '0;
                n_emit     = 1'b1;
                n_has_byte = 1'b1;
                n_len      = cnt_inc;
                if (cnt_inc == CW'(BUFFER_BYTES)) begin
                    n_frame_end = 1'b1;
                    n_count     = '0;
                end else begin
                    n_count = cnt_inc;
                end
            end
            CMD_TICK: begin
                // advance the idle time and close a pending frame on the gap
                n_idle = idle_inc;
                if (r_count != '0 && idle_inc >= gap.gap_ms) begin
                    n_emit      = 1'b1;
                    n_frame_end = 1'b1;
                    n_count     = '0;
                end
            end
            CMD_FLUSH: begin
                if (r_count != '0) begin
                    n_emit      = 1'b1;
                    n_frame_end = 1'b1;
                    n_count     = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idle      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_count <= n_count;
                r_idle  <= n_idle;
            end
            if (out_free) begin
                r_out_valid <= in_acc && n_emit;
            end
        end
    end

    // output word payload, loaded when the output register is free
    always_ff @(posedge i_clk) begin
        if (in_acc && n_emit && out_free) begin
            r_out_byte     <= n_has_byte ? i_rx_byte : '0;
            r_has_byte     <= n_has_byte;
            r_frame_end    <= n_frame_end;
            r_frame_length <= LEN_W'(n_len);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_has_byte     = r_has_byte;
    assign o_frame_end    = r_frame_end;
    assign o_frame_length = r_frame_length;

    // a byte always clears the idle time
    a_byte_clears_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_command == CMD_BYTE |=> r_idle == '0)
        else $error("idle time not cleared by a byte");

    // a flush always leaves no pending frame
    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_command == CMD_FLUSH |=> r_count == '0)
        else $error("frame still pending after flush");

    // no input is taken while the gap limit is being recomputed
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gap.busy |-> !o_in_ready)
        else $error("input accepted during gap recompute");

    // the frame counter never reaches the buffer size between words
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CW'(BUFFER_BYTES))
        else $error("frame counter overrun");

    // a word without a byte always closes a nonempty frame
    a_gap_end_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_has_byte |-> r_frame_end && (BUFFER_BYTES > 8191 ||
            r_frame_length != '0))
        else $error("empty frame closed");

    // the gap limit is never zero
    a_gap_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gap.gap_ms != '0)
        else $error("zero gap limit");

endmodule
